>>> src/dpb_pkg.sv
// dpb_pkg: shared constants, types and register codes for the depth pixel
// back-projection block. No dependencies; imported by every module in src.
package dpb_pkg;

  // Pixel position counters
  localparam int MAX_COORD_BITS = 12;
  localparam int COORD_W        = MAX_COORD_BITS;
  localparam int ROW_CFG_W      = 12;
  localparam int ROW_CMP_W      = (COORD_W > ROW_CFG_W) ? COORD_W : ROW_CFG_W;

  // Field widths
  localparam int DEPTH_W = 16;
  localparam int OUT_W   = 21;
  localparam int COEF_W  = 32;
  localparam int SKIP_W  = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Fixed point: Q.28 coefficients
  localparam int FRAC_BITS = 28;
  localparam int GP_W      = COEF_W + COORD_W + 1;   // gain * position
  localparam int SUM_W     = GP_W + 1;               // plus offset
  localparam int LO_W      = SUM_W / 2;              // low slice of the sum
  localparam int HI_W      = SUM_W - LO_W;           // signed high slice
  localparam int PLO_W     = LO_W + DEPTH_W;         // low partial product
  localparam int PHI_W     = HI_W + DEPTH_W + 1;     // high partial product
  localparam int PROD_W    = SUM_W + DEPTH_W + 1;    // full product
  localparam int RND_W     = PROD_W - FRAC_BITS;     // after rounding shift

  localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN = -(1 << (OUT_W - 1));

  // Register reset values
  localparam logic [SKIP_W-1:0]           FRAME_SKIP_RST = SKIP_W'(12);
  localparam logic [ROW_CFG_W-1:0]        FIRST_ROW_RST  = ROW_CFG_W'(50);
  localparam logic [DEPTH_W-1:0]          MIN_DEPTH_RST  = DEPTH_W'(300);
  localparam logic [DEPTH_W-1:0]          MAX_DEPTH_RST  = DEPTH_W'(8000);
  localparam logic signed [COEF_W-1:0]    X_GAIN_RST     = 32'sd385685;
  localparam logic signed [COEF_W-1:0]    X_OFFSET_RST   = -32'sd246839373;
  localparam logic signed [COEF_W-1:0]    Y_GAIN_RST     = 32'sd385685;
  localparam logic signed [COEF_W-1:0]    Y_OFFSET_RST   = -32'sd138848834;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_SKIP = 4'd0,
    CFG_FIRST_ROW  = 4'd1,
    CFG_MIN_DEPTH  = 4'd2,
    CFG_MAX_DEPTH  = 4'd3,
    CFG_X_GAIN     = 4'd4,
    CFG_X_OFFSET   = 4'd5,
    CFG_Y_GAIN     = 4'd6,
    CFG_Y_OFFSET   = 4'd7
  } cfg_idx_t;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_GAIN  = 5'b00010,
    ST_SUM   = 5'b00100,
    ST_PART  = 5'b01000,
    ST_ROUND = 5'b10000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // input word taken this cycle
    logic do_gain;    // gain * position
    logic do_sum;     // add offset
    logic do_part;    // partial products with depth
    logic do_round;   // combine and round
    logic load_out;   // move result to output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic keep;       // current input word yields a point
    logic out_free;   // output register can take a word
  } dp_stat_t;

endpackage

>>> src/depth_pixel_backprojection_top.sv
// depth_pixel_backprojection_top: depth raster to camera-frame points.
// Depends on dpb_pkg, dpb_ctrl and dpb_dp.
//
//   channel  | handshake            | words
//   in_      | in_valid / in_stall  | depth_raw, start_of_frame, end_of_line
//   out_     | out_valid/out_stall  | point_x, point_y, point_z
//   cfg_     | cfg_we               | cfg_index, cfg_wdata
//
// A dropped pixel is taken in the idle state. A kept pixel passes through the
// controller states for gain multiply, offset add, split depth multiply and
// round, and no new pixel is taken until it has left the round step.
// The output register lets the next pixel enter while a point waits; the
// round step holds while that register is full and out_stall is high.
// rst_n is synchronous; it restores register defaults and clears all counters.
module depth_pixel_backprojection_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dpb_pkg::DEPTH_W-1:0]        in_depth_raw,
  input  logic                               in_start_of_frame,
  input  logic                               in_end_of_line,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [dpb_pkg::OUT_W-1:0]   out_point_x,
  output logic signed [dpb_pkg::OUT_W-1:0]   out_point_y,
  output logic [dpb_pkg::DEPTH_W-1:0]        out_point_z
);
  import dpb_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dpb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dpb_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_depth_raw      (in_depth_raw),
    .in_start_of_frame (in_start_of_frame),
    .in_end_of_line    (in_end_of_line),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_point_x       (out_point_x),
    .out_point_y       (out_point_y),
    .out_point_z       (out_point_z),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule

>>> src/dpb_ctrl.sv
// dpb_ctrl: sequencing state machine for one kept pixel at a time.
// Depends on dpb_pkg.
module dpb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  dpb_pkg::dp_stat_t stat,
  output dpb_pkg::dp_cmd_t  cmd
);
  import dpb_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept && stat.keep) state_nxt = ST_GAIN;
      ST_GAIN:  state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_PART;
      ST_PART:  state_nxt = ST_ROUND;
      ST_ROUND: if (stat.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands
  always_comb begin
    cmd          = '0;
    cmd.accept   = accept;
    cmd.do_gain  = (state_r == ST_GAIN);
    cmd.do_sum   = (state_r == ST_SUM);
    cmd.do_part  = (state_r == ST_PART);
    cmd.do_round = (state_r == ST_ROUND) && stat.out_free;
    cmd.load_out = (state_r == ST_ROUND) && stat.out_free;
  end

endmodule

>>> src/dpb_dp.sv
// dpb_dp: configuration registers, frame/row/column tracking, depth window
// and the fixed-point back-projection arithmetic with output register.
// Depends on dpb_pkg.
module dpb_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [dpb_pkg::DEPTH_W-1:0]        in_depth_raw,
  input  logic                               in_start_of_frame,
  input  logic                               in_end_of_line,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [dpb_pkg::OUT_W-1:0]   out_point_x,
  output logic signed [dpb_pkg::OUT_W-1:0]   out_point_y,
  output logic [dpb_pkg::DEPTH_W-1:0]        out_point_z,
  input  dpb_pkg::dp_cmd_t                   cmd,
  output dpb_pkg::dp_stat_t                  stat
);
  import dpb_pkg::*;

  localparam logic [COORD_W-1:0]       COORD_MAX = {COORD_W{1'b1}};
  localparam logic signed [PROD_W-1:0] RND_HALF  = PROD_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [RND_W-1:0]  R_MAX     = RND_W'(OUT_MAX);
  localparam logic signed [RND_W-1:0]  R_MIN     = RND_W'(OUT_MIN);

  // Configuration registers
  logic [SKIP_W-1:0]        frame_skip_r;
  logic [ROW_CFG_W-1:0]     first_row_r;
  logic [DEPTH_W-1:0]       min_depth_r, max_depth_r;
  logic signed [COEF_W-1:0] x_gain_r, x_offset_r, y_gain_r, y_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_skip_r <= FRAME_SKIP_RST;
      first_row_r  <= FIRST_ROW_RST;
      min_depth_r  <= MIN_DEPTH_RST;
      max_depth_r  <= MAX_DEPTH_RST;
      x_gain_r     <= X_GAIN_RST;
      x_offset_r   <= X_OFFSET_RST;
      y_gain_r     <= Y_GAIN_RST;
      y_offset_r   <= Y_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_SKIP: frame_skip_r <= cfg_wdata[SKIP_W-1:0];
        CFG_FIRST_ROW:  first_row_r  <= cfg_wdata[ROW_CFG_W-1:0];
        CFG_MIN_DEPTH:  min_depth_r  <= cfg_wdata[DEPTH_W-1:0];
        CFG_MAX_DEPTH:  max_depth_r  <= cfg_wdata[DEPTH_W-1:0];
        CFG_X_GAIN:     x_gain_r     <= cfg_wdata;
        CFG_X_OFFSET:   x_offset_r   <= cfg_wdata;
        CFG_Y_GAIN:     y_gain_r     <= cfg_wdata;
        CFG_Y_OFFSET:   y_offset_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame selection and raster position
  logic [SKIP_W-1:0]  frame_count_r, frame_count_nxt;
  logic               frame_kept_r, frame_kept_nxt;
  logic [COORD_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [COORD_W-1:0] cur_col, cur_row;

  always_comb begin
    frame_count_nxt = frame_count_r;
    frame_kept_nxt  = frame_kept_r;
    cur_col         = col_r;
    cur_row         = row_r;
    if (in_start_of_frame) begin
      if (frame_count_r == '0 || frame_count_r >= frame_skip_r) begin
        frame_kept_nxt  = 1'b1;
        frame_count_nxt = SKIP_W'(1);
      end else begin
        frame_kept_nxt  = 1'b0;
        frame_count_nxt = frame_count_r + SKIP_W'(1);
      end
      cur_col = '0;
      cur_row = '0;
    end
    // advance position after this pixel
    col_nxt = cur_col;
    row_nxt = cur_row;
    if (in_end_of_line) begin
      col_nxt = '0;
      if (cur_row != COORD_MAX) row_nxt = cur_row + COORD_W'(1);
    end else if (cur_col != COORD_MAX) begin
      col_nxt = cur_col + COORD_W'(1);
    end
  end

  // Keep decision for the word on the input
  assign stat.keep = frame_kept_nxt
                  && (ROW_CMP_W'(cur_row) >= ROW_CMP_W'(first_row_r))
                  && (in_depth_raw > min_depth_r)
                  && (in_depth_raw <= max_depth_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
      frame_kept_r  <= 1'b0;
      col_r         <= '0;
      row_r         <= '0;
    end else if (cmd.accept) begin
      frame_count_r <= frame_count_nxt;
      frame_kept_r  <= frame_kept_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
    end
  end

  // Latched pixel operands
  logic [COORD_W-1:0] u_r, v_r;
  logic [DEPTH_W-1:0] z_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      u_r <= cur_col;
      v_r <= cur_row;
      z_r <= in_depth_raw;
    end
  end

  // Step 1: gain * position
  logic signed [GP_W-1:0] gx_r, gy_r;

  always_ff @(posedge clk) begin
    if (cmd.do_gain) begin
      gx_r <= x_gain_r * $signed({1'b0, u_r});
      gy_r <= y_gain_r * $signed({1'b0, v_r});
    end
  end

  // Step 2: add principal point term
  logic signed [SUM_W-1:0] sx_r, sy_r;

  always_ff @(posedge clk) begin
    if (cmd.do_sum) begin
      sx_r <= SUM_W'(gx_r) + SUM_W'(x_offset_r);
      sy_r <= SUM_W'(gy_r) + SUM_W'(y_offset_r);
    end
  end

  // Step 3: split products with depth (low slice unsigned, high slice signed)
  logic [PLO_W-1:0]        plx_r, ply_r;
  logic signed [PHI_W-1:0] phx_r, phy_r;

  always_ff @(posedge clk) begin
    if (cmd.do_part) begin
      plx_r <= sx_r[LO_W-1:0] * z_r;
      ply_r <= sy_r[LO_W-1:0] * z_r;
      phx_r <= $signed(sx_r[SUM_W-1:LO_W]) * $signed({1'b0, z_r});
      phy_r <= $signed(sy_r[SUM_W-1:LO_W]) * $signed({1'b0, z_r});
    end
  end

  // Step 4: recombine, round half up, floor shift, saturate
  logic signed [PROD_W-1:0] nx, ny;
  logic signed [RND_W-1:0]  rx, ry;
  logic signed [OUT_W-1:0]  qx, qy;

  always_comb begin
    nx = (PROD_W'(phx_r) <<< LO_W) + $signed(PROD_W'(plx_r)) + RND_HALF;
    ny = (PROD_W'(phy_r) <<< LO_W) + $signed(PROD_W'(ply_r)) + RND_HALF;
    rx = RND_W'(nx >>> FRAC_BITS);
    ry = RND_W'(ny >>> FRAC_BITS);
    priority if (rx > R_MAX) qx = OUT_W'(R_MAX);
    else if (rx < R_MIN)     qx = OUT_W'(R_MIN);
    else                     qx = rx[OUT_W-1:0];
    priority if (ry > R_MAX) qy = OUT_W'(R_MAX);
    else if (ry < R_MIN)     qy = OUT_W'(R_MIN);
    else                     qy = ry[OUT_W-1:0];
  end

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] px_r, py_r;
  logic [DEPTH_W-1:0]      pz_r;

  assign stat.out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out)      out_valid_nxt = 1'b1;
    else if (!out_stall)   out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_round) begin
      px_r <= qx;
      py_r <= qy;
      pz_r <= z_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_point_x = px_r;
  assign out_point_y = py_r;
  assign out_point_z = pz_r;

endmodule
